// File: hdl/utf8_stream_decode_validate_core_macros.svh
// Assertion macros used by the port-level checker of the UTF-8 decoder.
`ifndef UTF8_STREAM_DECODE_VALIDATE_CORE_MACROS_SVH
`define UTF8_STREAM_DECODE_VALIDATE_CORE_MACROS_SVH

// Property checked only out of reset.
`define U8SDV_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("utf8 decoder check failed");

// Property that also covers cycles in reset.
`define U8SDV_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("utf8 decoder reset check failed");

`endif

// File: hdl/utf8sdv_pkg.sv
// Types, status codes and helpers for the UTF-8 stream decoder.
package utf8sdv_pkg;

    localparam int unsigned CpWidth = 21;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD  = 2'd1;
    localparam logic [1:0] ST_BAD_CONT  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    typedef struct packed {
        logic [1:0]         bytes_remaining;
        logic [CpWidth-1:0] partial_value;
        logic [2:0]         current_width;
        logic               dropping;
    } dec_state_t;

    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic [2:0]         char_width;
        logic [1:0]         status;
        logic               string_done;
    } dec_result_t;

    // Width of a character from its lead byte; 0 for an illegal lead.
    function automatic logic [2:0] lead_width(input logic [7:0] b);
        logic [2:0] w;
        if (b[7] == 1'b0) begin
            w = 3'd1;
        end else if (b[7:5] == 3'b110) begin
            w = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            w = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            w = 3'd4;
        end else begin
            w = 3'd0;
        end
        return w;
    endfunction

    // Payload bits of a lead byte for a given width.
    function automatic logic [CpWidth-1:0] lead_payload(input logic [7:0] b,
                                                        input logic [2:0] w);
        logic [7:0] m;
        case (w)
            3'd1:    m = 8'd127;
            3'd2:    m = 8'd31;
            3'd3:    m = 8'd15;
            3'd4:    m = 8'd7;
            default: m = 8'd0;
        endcase
        return {{(CpWidth-8){1'b0}}, b & m};
    endfunction

endpackage

// File: hdl/utf8sdv_step.sv
// Per-byte decode step: current state and one byte to next state and result.
module utf8sdv_step (
    input  utf8sdv_pkg::dec_state_t  cur_state,
    input  logic [7:0]               data_byte,
    input  logic                     final_byte,
    output utf8sdv_pkg::dec_state_t  next_state,
    output logic                     emit,
    output utf8sdv_pkg::dec_result_t result
);

    logic [2:0]                      w;
    logic [utf8sdv_pkg::CpWidth-1:0] shifted;
    logic [1:0]                      rem_dec;

    assign w       = utf8sdv_pkg::lead_width(data_byte);
    assign shifted = {cur_state.partial_value[utf8sdv_pkg::CpWidth-7:0], data_byte[5:0]};
    assign rem_dec = cur_state.bytes_remaining - 2'd1;

    always_comb begin
        next_state = cur_state;
        emit       = 1'b0;
        result     = '0;

        if (cur_state.dropping) begin
            if (final_byte) begin
                next_state = '0;
            end
        end else if (cur_state.bytes_remaining == 2'd0) begin
            if (w == 3'd0) begin
                next_state          = '0;
                next_state.dropping = ~final_byte;
                emit                = 1'b1;
                result.status       = utf8sdv_pkg::ST_BAD_LEAD;
                result.string_done  = 1'b1;
            end else if (w == 3'd1) begin
                next_state         = '0;
                emit               = 1'b1;
                result.code_point  = utf8sdv_pkg::lead_payload(data_byte, w);
                result.char_width  = 3'd1;
                result.status      = utf8sdv_pkg::ST_OK;
                result.string_done = final_byte;
            end else if (final_byte) begin
                // multi-byte lead on the last byte: cut short
                next_state         = '0;
                emit               = 1'b1;
                result.status      = utf8sdv_pkg::ST_TRUNCATED;
                result.string_done = 1'b1;
            end else begin
                next_state.partial_value   = utf8sdv_pkg::lead_payload(data_byte, w);
                next_state.current_width   = w;
                next_state.bytes_remaining = 2'(w - 3'd1);
            end
        end else if (data_byte[7:6] != 2'b10) begin
            next_state          = '0;
            next_state.dropping = ~final_byte;
            emit                = 1'b1;
            result.status       = utf8sdv_pkg::ST_BAD_CONT;
            result.string_done  = 1'b1;
        end else if (rem_dec == 2'd0) begin
            next_state         = '0;
            emit               = 1'b1;
            result.code_point  = shifted;
            result.char_width  = cur_state.current_width;
            result.status      = utf8sdv_pkg::ST_OK;
            result.string_done = final_byte;
        end else if (final_byte) begin
            next_state         = '0;
            emit               = 1'b1;
            result.status      = utf8sdv_pkg::ST_TRUNCATED;
            result.string_done = 1'b1;
        end else begin
            next_state.partial_value   = shifted;
            next_state.bytes_remaining = rem_dec;
        end
    end

endmodule

// File: hdl/utf8_stream_decode_validate_core.sv
// Top level of the UTF-8 stream decoder and validator.
// An accepted byte passes through the input register and then the result register to m_.
// Throughput: one byte per cycle while m_ does not stall; the decode state updates in one short step.
// Bytes that complete no character (leads, middle continuations, dropped
// bytes) produce no m_ transfer. Backpressure on m_ stalls the input register.
// Reset (aresetn low, synchronous) empties both registers and clears the state.
module utf8_stream_decode_validate_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [20:0] m_code_point,
    output logic [2:0]  m_char_width,
    output logic [1:0]  m_status,
    output logic        m_string_done
);

    // Input register: holds one accepted byte until the decode step takes it.
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_final_reg;

    // Decoder state, updated once per processed byte.
    utf8sdv_pkg::dec_state_t state_reg, state_next;

    // Result register feeding the m_ channel.
    logic                     out_valid_reg, out_valid_next;
    utf8sdv_pkg::dec_result_t out_reg;

    logic                     step_fire;
    logic                     step_emit;
    utf8sdv_pkg::dec_result_t step_result;
    logic                     s_xfer;

    // The held byte moves through the decode step whenever the result
    // register is empty or is being drained this cycle.
    assign step_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;
    assign s_xfer    = s_valid && s_ready;

    utf8sdv_step u_step (
        .cur_state  (state_reg),
        .data_byte  (in_byte_reg),
        .final_byte (in_final_reg),
        .next_state (state_next),
        .emit       (step_emit),
        .result     (step_result)
    );

    always_comb begin
        in_valid_next = s_xfer ? 1'b1 : (step_fire ? 1'b0 : in_valid_reg);
        if (step_fire) begin
            out_valid_next = step_emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step_fire) begin
                state_reg <= state_next;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_byte_reg  <= s_data_byte;
            in_final_reg <= s_final_byte;
        end
        if (step_fire && step_emit) begin
            out_reg <= step_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_code_point  = out_reg.code_point;
    assign m_char_width  = out_reg.char_width;
    assign m_status      = out_reg.status;
    assign m_string_done = out_reg.string_done;

endmodule

// File: hdl/utf8sdv_checker.sv
// Port-level checker for the UTF-8 decoder, bound to the top level.
`include "utf8_stream_decode_validate_core_macros.svh"

module utf8sdv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_data_byte,
    input logic        s_final_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [20:0] m_code_point,
    input logic [2:0]  m_char_width,
    input logic [1:0]  m_status,
    input logic        m_string_done
);

    // stalled result holds
    `U8SDV_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_code_point) && $stable(m_status))

    // error results always close the string
    `U8SDV_ASSERT(a_err_done, m_valid && (m_status != utf8sdv_pkg::ST_OK) |-> m_string_done)

    // error results carry no character
    `U8SDV_ASSERT(a_err_zero, m_valid && (m_status != utf8sdv_pkg::ST_OK) |-> (m_code_point == 21'd0) && (m_char_width == 3'd0))

    // ok results have a width of one to four bytes
    `U8SDV_ASSERT(a_ok_width, m_valid && (m_status == utf8sdv_pkg::ST_OK) |-> (m_char_width != 3'd0) && (m_char_width <= 3'd4))

    // nothing on the output right after reset
    `U8SDV_ASSERT_RST(a_rst_empty, !aresetn |=> !m_valid)

endmodule

bind utf8_stream_decode_validate_core utf8sdv_checker u_utf8sdv_checker (.*);

// File: bench/utf8_stream_decode_validate_core_checker.sv
// Checker for the UTF-8 decoder: predicts each result from the byte stream and compares it.
module utf8_stream_decode_validate_core_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_final_byte,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [20:0] m_code_point,
    input  logic [2:0]  m_char_width,
    input  logic [1:0]  m_status,
    input  logic        m_string_done,
    output int          fail_count,
    output int          pending
);

    // Decoder state as predicted from accepted bytes.
    logic [1:0]                      need_cont;
    logic [utf8sdv_pkg::CpWidth-1:0] cp_acc;
    logic [2:0]                      char_len;
    logic                            skipping;

    utf8sdv_pkg::dec_result_t expected_chars[$];
    int                       failures;

    initial begin
        failures  = 0;
        need_cont = '0;
        cp_acc    = '0;
        char_len  = '0;
        skipping  = 1'b0;
    end

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("[%0t] %s", $realtime, msg);
        end
    endtask

    task automatic clear_char();
        need_cont = '0;
        cp_acc    = '0;
        char_len  = '0;
    endtask

    // Advance the predicted state by one byte; queue a result when one is due.
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        utf8sdv_pkg::dec_result_t r;
        logic                     emit;
        logic [2:0]               w;
        r    = '0;
        emit = 1'b0;
        if (skipping) begin
            if (fin) begin
                skipping = 1'b0;
                clear_char();
            end
        end else if (need_cont == 2'd0) begin
            casez (b)
                8'b0???????: w = 3'd1;
                8'b110?????: w = 3'd2;
                8'b1110????: w = 3'd3;
                8'b11110???: w = 3'd4;
                default:     w = 3'd0;
            endcase
            if (w == 3'd0) begin
                emit          = 1'b1;
                r.status      = utf8sdv_pkg::ST_BAD_LEAD;
                r.string_done = 1'b1;
                skipping      = !fin;
                clear_char();
            end else if (w == 3'd1) begin
                emit          = 1'b1;
                r.code_point  = {{(utf8sdv_pkg::CpWidth-7){1'b0}}, b[6:0]};
                r.char_width  = 3'd1;
                r.status      = utf8sdv_pkg::ST_OK;
                r.string_done = fin;
                clear_char();
            end else if (fin) begin
                // lead byte alone at the end of the string
                emit          = 1'b1;
                r.status      = utf8sdv_pkg::ST_TRUNCATED;
                r.string_done = 1'b1;
                clear_char();
            end else begin
                char_len  = w;
                need_cont = 2'(w - 3'd1);
                case (w)
                    3'd2:    cp_acc = {{(utf8sdv_pkg::CpWidth-5){1'b0}}, b[4:0]};
                    3'd3:    cp_acc = {{(utf8sdv_pkg::CpWidth-4){1'b0}}, b[3:0]};
                    default: cp_acc = {{(utf8sdv_pkg::CpWidth-3){1'b0}}, b[2:0]};
                endcase
            end
        end else if (b[7:6] != 2'b10) begin
            emit          = 1'b1;
            r.status      = utf8sdv_pkg::ST_BAD_CONT;
            r.string_done = 1'b1;
            skipping      = !fin;
            clear_char();
        end else begin
            cp_acc    = {cp_acc[utf8sdv_pkg::CpWidth-7:0], b[5:0]};
            need_cont = need_cont - 2'd1;
            if (need_cont == 2'd0) begin
                emit          = 1'b1;
                r.code_point  = cp_acc;
                r.char_width  = char_len;
                r.status      = utf8sdv_pkg::ST_OK;
                r.string_done = fin;
                clear_char();
            end else if (fin) begin
                emit          = 1'b1;
                r.status      = utf8sdv_pkg::ST_TRUNCATED;
                r.string_done = 1'b1;
                clear_char();
            end
        end
        if (emit) begin
            expected_chars.push_back(r);
        end
    endtask

    always @(posedge aclk) begin
        utf8sdv_pkg::dec_result_t got;
        utf8sdv_pkg::dec_result_t want;
        if (!aresetn) begin
            expected_chars.delete();
            skipping = 1'b0;
            clear_char();
        end else begin
            if (m_valid && m_ready) begin
                got = '{m_code_point, m_char_width, m_status, m_string_done};
                if (expected_chars.size() == 0) begin
                    note_failure($sformatf("unexpected result cp=%06h w=%0d st=%0d done=%0b",
                        got.code_point, got.char_width, got.status, got.string_done));
                end else begin
                    want = expected_chars.pop_front();
                    if (got !== want) begin
                        note_failure($sformatf(
                            "mismatch: exp cp=%06h w=%0d st=%0d done=%0b, got cp=%06h w=%0d st=%0d done=%0b",
                            want.code_point, want.char_width, want.status, want.string_done,
                            got.code_point, got.char_width, got.status, got.string_done));
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_byte(s_data_byte, s_final_byte);
            end
        end
        fail_count <= failures;
        pending    <= expected_chars.size();
    end

endmodule

// File: bench/utf8_stream_decode_validate_core_tb.sv
// Testbench top for the UTF-8 stream decoder: drives byte strings and gives the verdict.
module utf8_stream_decode_validate_core_tb;

    // Cycles without any transfer before the run is declared hung. Real gaps
    // come from random idling plus the input and result registers.
    localparam int StallLimit = 2000;

    // How a random character is spoiled, if at all.
    typedef enum int {
        FAULT_NONE,
        FAULT_LEAD,
        FAULT_CONT,
        FAULT_CUT
    } fault_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic [7:0]  s_data_byte   = 8'h00;
    logic        s_final_byte  = 1'b0;
    logic        m_ready       = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [20:0] m_code_point;
    logic [2:0]  m_char_width;
    logic [1:0]  m_status;
    logic        m_string_done;

    int fail_count;
    int pending;

    // No idling on either side while calm is set.
    logic calm = 1'b0;

    int          bytes_sent = 0;
    logic [7:0]  str_bytes[$];

    always #4 aclk = ~aclk;

    utf8_stream_decode_validate_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_point  (m_code_point),
        .m_char_width  (m_char_width),
        .m_status      (m_status),
        .m_string_done (m_string_done)
    );

    utf8_stream_decode_validate_core_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_final_byte  (s_final_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_point  (m_code_point),
        .m_char_width  (m_char_width),
        .m_status      (m_status),
        .m_string_done (m_string_done),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // Result side: m_ready drops at random, when a draw of 0 to 99 falls below 14, unless calm.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= 14);
        end
    end

    // Watchdog: any transfer on either channel resets the count.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < StallLimit) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("utf8_stream_decode_validate_core regression: fail");
        $finish;
    end

    // One byte transfer, with random idle cycles ahead of it. Valid only drops
    // in the idle cycles, so it never falls and rises in the same step.
    task automatic send_byte(input logic [7:0] b, input logic fin);
        while (!calm && $urandom_range(0, 99) < 14) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_final_byte <= fin;
        // s_ready read here is the value the edge itself saw
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Send the queued string, final flag on its last byte.
    task automatic send_string();
        int n;
        n = str_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(str_bytes[i], i == n - 1);
        end
        str_bytes.delete();
    endtask

    // Hold the sender off until every predicted result has come out. The first
    // edge lets the checker count the last transfer.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    initial begin
        int         n;
        int         w;
        int         conts;
        bit         pressured;
        fault_t     fault;
        logic [7:0] lead;
        logic [7:0] cb;

        pressured = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed strings: ASCII extremes and NUL, the widest code point of
        // each width, a multi-character string (done only on the last), and
        // each error kind, bad lead and bad continuation also on non-final bytes.
        str_bytes = '{8'h00};                      send_string();
        str_bytes = '{8'h7F};                      send_string();
        str_bytes = '{8'h41, 8'hC3, 8'hA9};        send_string();
        str_bytes = '{8'hDF, 8'hBF};               send_string();
        str_bytes = '{8'hEF, 8'hBF, 8'hBF};        send_string();
        str_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF}; send_string();
        // stray continuation as lead, rest of string dropped
        str_bytes = '{8'h80, 8'h41, 8'hE2};        send_string();
        // 11111xxx lead on the final byte
        str_bytes = '{8'hFF};                      send_string();
        // bad continuation that is also final still reports bad continuation
        str_bytes = '{8'hC3, 8'h41};               send_string();
        // bad continuation mid string, then drop up to the final byte
        str_bytes = '{8'hE2, 8'hC0, 8'h80};        send_string();
        // truncated mid character and right after the lead
        str_bytes = '{8'hE2, 8'h82};               send_string();
        str_bytes = '{8'hF0};                      send_string();

        drain_results();

        // Random strings: mostly well formed with random payload bits, some
        // characters spoiled, and some strings of pure noise.
        while (bytes_sent < 520) begin
            calm <= (bytes_sent >= 220 && bytes_sent < 320);
            n = $urandom_range(1, 6);
            if ($urandom_range(0, 99) < 12) begin
                for (int i = 0; i < n; i++) begin
                    str_bytes.push_back(8'($urandom_range(0, 255)));
                end
            end else begin
                for (int c = 0; c < n; c++) begin
                    w     = $urandom_range(1, 4);
                    fault = FAULT_NONE;
                    if ($urandom_range(0, 99) < 10) begin
                        fault = fault_t'($urandom_range(1, 3));
                    end
                    case (w)
                        1:       lead = 8'($urandom_range(0, 127));
                        2:       lead = 8'hC0 | 8'($urandom_range(0, 31));
                        3:       lead = 8'hE0 | 8'($urandom_range(0, 15));
                        default: lead = 8'hF0 | 8'($urandom_range(0, 7));
                    endcase
                    if (fault == FAULT_LEAD) begin
                        lead = 8'($urandom_range(0, 255));
                    end
                    str_bytes.push_back(lead);
                    conts = w - 1;
                    if (fault == FAULT_CUT && w > 1) begin
                        conts = $urandom_range(0, w - 2);
                    end
                    for (int k = 0; k < conts; k++) begin
                        cb = 8'h80 | 8'($urandom_range(0, 63));
                        if (fault == FAULT_CONT && k == 0) begin
                            cb = 8'($urandom_range(0, 255));
                        end
                        str_bytes.push_back(cb);
                    end
                    // a cut character ends the string
                    if (fault == FAULT_CUT && w > 1) break;
                end
            end
            send_string();
            if (!pressured && bytes_sent >= 380) begin
                pressured = 1'b1;
                drain_results();
            end
        end

        calm <= 1'b0;
        drain_results();
        // room for any late, unexpected transfer to show up
        repeat (8) @(posedge aclk);

        if (fail_count == 0) begin
            $display("utf8_stream_decode_validate_core regression: pass");
        end else begin
            $display("utf8_stream_decode_validate_core regression: fail");
        end
        $finish;
    end

endmodule
